>>> rtl/core/kinematic_vehicle_rollout_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the kinematic vehicle rollout block
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef KINEMATIC_VEHICLE_ROLLOUT_ASSERT_SVH
`define KINEMATIC_VEHICLE_ROLLOUT_ASSERT_SVH
`ifndef SYNTHESIS
`define KVR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KVR_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KVR_ASSERT(lbl, clk, rst_n, prop, msg)
`define KVR_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/core/kvr_pkg.sv
// ----------------------------------------------------------------------------
// kvr_pkg
// Shared types, constants and tables of the kinematic vehicle rollout.
// ----------------------------------------------------------------------------
`default_nettype none
package kvr_pkg;
  localparam int unsigned CordicIterations = 16;
  localparam int unsigned IterUsed = (CordicIterations > 30) ? 30 : CordicIterations;
  localparam int unsigned IterW = 5;
  localparam logic [15:0] TimeStepReset = 16'd6554;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_VDT, ST_MUL_DTDT, ST_MUL_ADT, ST_MUL_ADTDT, ST_MUL_WDT, ST_CORDIC,
    ST_MUL_DX, ST_MUL_DY, ST_DONE
  } kvr_state_e;

  typedef enum logic [2:0] {
    MS_VDT, MS_DTDT, MS_ADT, MS_ADTDT, MS_WDT, MS_DX, MS_DY
  } kvr_msel_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } kvr_cordic_ctl_t;

  function automatic logic [31:0] atan_lut(input logic [IterW-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;  5'd2: r = 32'd167458907;
      5'd3: r = 32'd85004756;   5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;    5'd8: r = 32'd2670163;
      5'd9: r = 32'd1335087;    5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;     5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;     5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;      5'd20: r = 32'd652;
      5'd21: r = 32'd326;       5'd22: r = 32'd163;       5'd23: r = 32'd81;
      5'd24: r = 32'd41;        5'd25: r = 32'd20;        5'd26: r = 32'd10;
      5'd27: r = 32'd5;         5'd28: r = 32'd3;         5'd29: r = 32'd1;
      default: r = 32'd1;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) r = 32'h7fffffff;
    else if (v < -34'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/kvr_cordic.sv
// ----------------------------------------------------------------------------
// kvr_cordic
// Iterative rotation CORDIC: one micro-rotation per cycle, quadrant fold.
// ----------------------------------------------------------------------------
`default_nettype none
module kvr_cordic (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [31:0]              angle_i,
  output kvr_pkg::kvr_cordic_ctl_t      ctl_o,
  output logic signed [33:0]            cos_o,
  output logic signed [33:0]            sin_o
);
  import kvr_pkg::*;

  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [32:0] z_q, z_d;
  logic [1:0]         quad_q, quad_d;
  logic [IterW-1:0]   it_q, it_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [31:0]        biased, resid;
  logic signed [33:0] dx, dy;
  logic signed [32:0] at;

  assign biased = angle_i + 32'h2000_0000;
  assign resid  = angle_i - {biased[31:30], 30'd0};
  assign dx = x_q >>> it_q;
  assign dy = y_q >>> it_q;
  assign at = {1'b0, atan_lut(it_q)};

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; quad_d = quad_q; it_d = it_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      x_d = CordicGain; y_d = '0; z_d = {resid[31], resid};
      quad_d = biased[31:30]; it_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_d = x_q - dy; y_d = y_q + dx; z_d = z_q - at;
      end else begin
        x_d = x_q + dy; y_d = y_q - dx; z_d = z_q + at;
      end
      it_d = it_q + 1'b1;
      if (it_q == IterW'(IterUsed - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; it_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; quad_q <= quad_d;
  end

  always_comb begin
    case (quad_q)
      2'd0: begin cos_o = x_q;  sin_o = y_q;  end
      2'd1: begin cos_o = -y_q; sin_o = x_q;  end
      2'd2: begin cos_o = -x_q; sin_o = -y_q; end
      default: begin cos_o = y_q; sin_o = -x_q; end
    endcase
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign ctl_o.done  = done_q;
endmodule
`default_nettype wire

>>> rtl/core/kinematic_vehicle_rollout.sv
// ----------------------------------------------------------------------------
// kinematic_vehicle_rollout
// Unicycle kinematic step engine with shared multiplier and CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one item: a load of the
//    start state (operation 0) or one control step (operation 1).
//  - Output channel (out_valid_o/out_ready_i) returns the new state per item.
//  - Config channel (cfg_valid_i/cfg_ready_o) writes time_step, only when idle.
//  - A load's result is valid the cycle after acceptance.
//  - A step starts the CORDIC (one micro-rotation per cycle) while five
//    products run on the shared multiplier; once the CORDIC is done, two
//    more products follow and the new state is written in ST_DONE.
//  - The CORDIC iteration loop sets the rate; one item is in work at a time.
//  - The result sits in the output register until taken; a stalled
//    receiver holds the block, which then takes no new item.
//  - Reset clears state to zero and time_step to 6554.
// ----------------------------------------------------------------------------
`default_nettype none
`include "kinematic_vehicle_rollout_assert.svh"
module kinematic_vehicle_rollout (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [31:0] start_x_i,
  input  wire logic [31:0] start_y_i,
  input  wire logic [31:0] start_speed_i,
  input  wire logic [31:0] start_heading_i,
  input  wire logic [31:0] accel_i,
  input  wire logic [31:0] yaw_rate_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      pos_x_o,
  output logic [31:0]      pos_y_o,
  output logic [31:0]      speed_o,
  output logic [31:0]      heading_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);
  import kvr_pkg::*;

  kvr_state_e state_q, state_d;
  logic [15:0] dt_q;
  logic [31:0] x_q, y_q, v_q, h_q;
  logic [31:0] a_q, w_q;
  logic [31:0] dt2_q;
  logic signed [63:0] vdt_q, adt_q, adtdt_q, wdt_q, prod_q;
  logic signed [33:0] dist_q;
  logic signed [33:0] cos_q, sin_q;
  logic signed [33:0] cw, sw;
  logic signed [33:0] ma;
  logic signed [34:0] mb;
  logic signed [68:0] mp;
  kvr_msel_e msel;
  kvr_cordic_ctl_t cctl;
  logic cstart, acc;
  logic [31:0] hinc;

  assign acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_o;
  assign cfg_ready_o = (state_q == ST_IDLE);

  kvr_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cstart), .angle_i(h_q),
    .ctl_o(cctl), .cos_o(cw), .sin_o(sw)
  );

  always_comb begin
    case (msel)
      MS_VDT:   begin ma = 34'(signed'(v_q)); mb = 35'(signed'({1'b0, dt_q})); end
      MS_DTDT:  begin
        ma = 34'(signed'({1'b0, dt_q})); mb = 35'(signed'({1'b0, dt_q}));
      end
      MS_ADT:   begin ma = 34'(signed'(a_q)); mb = 35'(signed'({1'b0, dt_q})); end
      MS_ADTDT: begin ma = 34'(signed'(a_q)); mb = 35'(signed'({1'b0, dt2_q})); end
      MS_WDT:   begin ma = 34'(signed'(w_q)); mb = 35'(signed'({1'b0, dt_q})); end
      MS_DX:    begin ma = dist_q; mb = 35'(cos_q); end
      default:  begin ma = dist_q; mb = 35'(sin_q); end
    endcase
    mp = 69'(ma) * 69'(mb);
  end

  always_comb begin
    state_d = state_q; cstart = 1'b0; msel = MS_VDT;
    case (state_q)
      ST_IDLE:      if (acc && operation_i) state_d = ST_MUL_VDT;
      ST_MUL_VDT:   begin msel = MS_VDT;   state_d = ST_MUL_DTDT; cstart = 1'b1; end
      ST_MUL_DTDT:  begin msel = MS_DTDT;  state_d = ST_MUL_ADT; end
      ST_MUL_ADT:   begin msel = MS_ADT;   state_d = ST_MUL_ADTDT; end
      ST_MUL_ADTDT: begin msel = MS_ADTDT; state_d = ST_MUL_WDT; end
      ST_MUL_WDT:   begin msel = MS_WDT;   state_d = ST_CORDIC; end
      ST_CORDIC:    begin
        msel = MS_WDT;
        if (cctl.done) state_d = ST_MUL_DX;
      end
      ST_MUL_DX:    begin msel = MS_DX;    state_d = ST_MUL_DY; end
      ST_MUL_DY:    begin msel = MS_DY;    state_d = ST_DONE; end
      ST_DONE:      state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  assign hinc = wdt_q[47:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; out_valid_o <= 1'b0; dt_q <= TimeStepReset;
      x_q <= '0; y_q <= '0; v_q <= '0; h_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) dt_q <= cfg_data_i;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (acc && !operation_i) begin
        x_q <= start_x_i; y_q <= start_y_i; v_q <= start_speed_i; h_q <= start_heading_i;
        out_valid_o <= 1'b1;
      end
      if (state_q == ST_DONE) begin
        x_q <= sat32(34'(signed'(x_q)) + 34'(vdt_q >>> 30));
        y_q <= sat32(34'(signed'(y_q)) + 34'(prod_q >>> 30));
        v_q <= sat32(34'(signed'(v_q)) + 34'(adt_q >>> 16));
        h_q <= h_q + hinc;
        out_valid_o <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_q <= accel_i; w_q <= yaw_rate_i;
    end
    prod_q <= mp[63:0];
    case (state_q)
      ST_MUL_DTDT:  vdt_q <= prod_q;
      ST_MUL_ADT:   dt2_q <= prod_q[31:0];
      ST_MUL_ADTDT: adt_q <= prod_q;
      ST_MUL_WDT:   adtdt_q <= prod_q;
      ST_CORDIC: begin
        wdt_q <= prod_q;
        dist_q <= 34'(vdt_q >>> 16) + 34'(adtdt_q >>> 33);
        cos_q <= cw; sin_q <= sw;
      end
      ST_MUL_DY:    vdt_q <= prod_q;
      default: ;
    endcase
  end

  assign pos_x_o = x_q;
  assign pos_y_o = y_q;
  assign speed_o = v_q;
  assign heading_o = h_q;

  `KVR_ASSERT(a_no_acc_busy, clk_i, rst_ni, (state_q != ST_IDLE) |-> !in_ready_o, "ready while busy")
  `KVR_ASSERT(a_cordic_in_time, clk_i, rst_ni, cctl.start |=> cctl.busy, "cordic not started")
  `KVR_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o, "result dropped")
endmodule
`default_nettype wire
